FILE: design/tnwc_pkg.sv
// Shared types and constants of the NewReno window control block.
// Depends on nothing; every other design file refers to it by scoped names.
`default_nettype none

package tnwc_pkg;

	localparam int WIN_W  = 32;
	localparam int MSS_W  = 16;
	localparam int DUP_W  = 8;
	localparam int CMD_W  = 3;

	localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ACK     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DUP_ACK = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TIMEOUT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESTART = 3'd4;

	localparam logic [WIN_W-1:0] THRESH_RESET = 32'h7FFF_FFFF;
	localparam logic [MSS_W-1:0] MSS_RESET    = 16'd1460;
	localparam logic [WIN_W-1:0] IW_RESET     = 32'd14600;
	localparam logic [DUP_W-1:0] RTHR_RESET   = 8'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;         // capture the request and its precomputed terms
		logic commit_exec;  // update state from the path without a divide
		logic div_start;    // launch the congestion avoidance divide
		logic commit_div;   // update window from the quotient
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic needs_div;
		logic div_done;
	} ctrl_status_t;

	function automatic logic [WIN_W-1:0] sat_add(input logic [WIN_W-1:0] a,
		input logic [WIN_W-1:0] b);
		logic [WIN_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WIN_W] ? {WIN_W{1'b1}} : s[WIN_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: design/tcp_newreno_window_control_core.sv
// A request is captured in ST_IDLE, evaluated in ST_EXEC and committed to the result
// register; a congestion avoidance ack instead passes through ST_DIVIDE and ST_FINISH,
// where the 32-step radix-2 divider computes mss*mss/cwnd.
// Only one request is in flight at a time; the next is taken once the result is committed.
// A new request is taken while the previous result waits in the output register.
// Reset: asynchronous, active low; restores configuration, window state, sequencer state and the valid flag at once.
`default_nettype none

module tcp_newreno_window_control_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// request stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [31:0] acked_bytes, [63:32] oldest_unacked, [95:64] highest_sent,
	// [103:96] dup_ack_count
	input  wire logic [103:0] s_tdata,
	// [2:0] command
	input  wire logic [2:0]   s_tuser,
	// result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [31:0] congestion_window, [63:32] slow_start_threshold
	output logic [63:0]       m_tdata,
	// [0] in_recovery
	output logic [0:0]        m_tuser
);

	localparam logic [1:0] REG_MSS  = 2'd0;
	localparam logic [1:0] REG_IW   = 2'd1;
	localparam logic [1:0] REG_RTHR = 2'd2;

	logic [tnwc_pkg::MSS_W-1:0] mss_q;
	logic [tnwc_pkg::WIN_W-1:0] iw_q;
	logic [tnwc_pkg::DUP_W-1:0] rthr_q;
	logic                       wr_en;
	logic [1:0]                 reg_idx;

	tnwc_pkg::ctrl_cmd_t    cmd;
	tnwc_pkg::ctrl_status_t status;

	logic [tnwc_pkg::WIN_W-1:0] cwnd;
	logic [tnwc_pkg::WIN_W-1:0] ssthresh;
	logic                       recov;

	// Register file: always ready, write on the access phase.
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mss_q  <= tnwc_pkg::MSS_RESET;
			iw_q   <= tnwc_pkg::IW_RESET;
			rthr_q <= tnwc_pkg::RTHR_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MSS:  mss_q  <= pwdata[tnwc_pkg::MSS_W-1:0];
				REG_IW:   iw_q   <= pwdata;
				REG_RTHR: rthr_q <= pwdata[tnwc_pkg::DUP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MSS:  prdata = {16'd0, mss_q};
			REG_IW:   prdata = iw_q;
			REG_RTHR: prdata = {24'd0, rthr_q};
			default:  prdata = '0;
		endcase
	end

	// Sequencer: accept, evaluate, optionally divide, then commit the result.
	tnwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Window state and arithmetic; the result register lives here as well.
	tnwc_datapath u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.status               (status),
		.mss                  (mss_q),
		.init_win             (iw_q),
		.reorder_thr          (rthr_q),
		.command              (s_tuser),
		.acked_bytes          (s_tdata[31:0]),
		.oldest_unacked       (s_tdata[63:32]),
		.highest_sent         (s_tdata[95:64]),
		.dup_ack_count        (s_tdata[103:96]),
		.congestion_window    (cwnd),
		.slow_start_threshold (ssthresh),
		.in_recovery          (recov)
	);

	assign m_tdata = {ssthresh, cwnd};
	assign m_tuser = recov;

`ifndef SYNTH
	// one request at a time: after an accept the input side closes
	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in flight");

	// a divide launch is never followed directly by a commit
	a_div_no_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !(cmd.commit_exec || cmd.commit_div))
		else $error("commit right after divide launch");

	// a commit never coincides with accepting a new request
	a_commit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit_exec || cmd.commit_div) |-> !cmd.load)
		else $error("commit and load in the same cycle");
`endif

endmodule

`default_nettype wire

FILE: design/tnwc_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on tnwc_pkg for the default width.
`default_nettype none

module tnwc_divider #(
	parameter int WIDTH = tnwc_pkg::WIN_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] dividend,
	input  wire logic [WIDTH-1:0] divisor,
	output logic                  done,
	output logic [WIDTH-1:0]      quotient
);

	localparam int CNT_W = $clog2(WIDTH);

	logic             active_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] den_q;
	logic [WIDTH:0]   shifted;
	logic [WIDTH+1:0] diff;
	logic             take;

	assign shifted  = {rem_q, quo_q[WIDTH-1]};
	assign diff     = {1'b0, shifted} - {2'b00, den_q};
	assign take     = ~diff[WIDTH+1];
	assign done     = active_q && (cnt_q == CNT_W'(WIDTH - 1));
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (active_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (active_q) begin
			rem_q <= take ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], take};
		end
	end

endmodule

`default_nettype wire

FILE: design/tnwc_datapath.sv
// Window state, request capture, next-state arithmetic and result register.
// Depends on tnwc_pkg and tnwc_divider.
`default_nettype none

module tnwc_datapath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire tnwc_pkg::ctrl_cmd_t                  cmd,
	output tnwc_pkg::ctrl_status_t                    status,
	input  wire logic [tnwc_pkg::MSS_W-1:0]           mss,
	input  wire logic [tnwc_pkg::WIN_W-1:0]           init_win,
	input  wire logic [tnwc_pkg::DUP_W-1:0]           reorder_thr,
	input  wire logic [tnwc_pkg::CMD_W-1:0]           command,
	input  wire logic [tnwc_pkg::WIN_W-1:0]           acked_bytes,
	input  wire logic [tnwc_pkg::WIN_W-1:0]           oldest_unacked,
	input  wire logic [tnwc_pkg::WIN_W-1:0]           highest_sent,
	input  wire logic [tnwc_pkg::DUP_W-1:0]           dup_ack_count,
	output logic [tnwc_pkg::WIN_W-1:0]                congestion_window,
	output logic [tnwc_pkg::WIN_W-1:0]                slow_start_threshold,
	output logic                                      in_recovery
);

	localparam int W     = tnwc_pkg::WIN_W;
	localparam int CAP_W = tnwc_pkg::MSS_W + 1;
	localparam int PRD_W = tnwc_pkg::MSS_W + tnwc_pkg::DUP_W;

	// architectural state
	logic [W-1:0] window_q;
	logic [W-1:0] thresh_q;
	logic         recov_q;
	logic [W-1:0] rpoint_q;

	// captured request terms
	logic [tnwc_pkg::CMD_W-1:0] cmd_q;
	logic [W-2:0]               half_q;
	logic [PRD_W-1:0]           prod_q;
	logic [CAP_W-1:0]           cap_q;
	logic                       seq_ge_q;
	logic                       dup_ok_q;
	logic [W-1:0]               sent_q;

	logic [CAP_W-1:0] cap_lim;
	logic [W-1:0]     flight;
	logic [W-1:0]     una_off;
	logic [W-1:0]     thr_new;
	logic [W-1:0]     win_nx;
	logic [W-1:0]     thr_nx;
	logic             rec_nx;
	logic [W-1:0]     rp_nx;
	logic [W-1:0]     mss_sq;
	logic             div_done;
	logic [W-1:0]     quotient;
	logic [W-1:0]     ca_inc;

	assign cap_lim = {mss, 1'b0};
	assign flight  = highest_sent - oldest_unacked;
	assign una_off = oldest_unacked - rpoint_q;
	assign mss_sq  = W'({16'd0, mss} * {16'd0, mss});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= command;
			half_q   <= flight[W-1:1];
			prod_q   <= PRD_W'(mss) * PRD_W'(dup_ack_count);
			cap_q    <= (acked_bytes < W'(cap_lim)) ? acked_bytes[CAP_W-1:0] : cap_lim;
			seq_ge_q <= ~una_off[W-1];
			dup_ok_q <= dup_ack_count >= reorder_thr;
			sent_q   <= highest_sent;
		end
	end

	tnwc_divider #(
		.WIDTH(W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mss_sq),
		.divisor  (window_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign ca_inc = (quotient == '0) ? W'(1) : quotient;
	assign thr_new = ({1'b0, half_q} > init_win) ? {1'b0, half_q} : init_win;

	assign status.needs_div = (cmd_q == tnwc_pkg::CMD_ACK) && !recov_q && (window_q > thresh_q);
	assign status.div_done  = div_done;

	always_comb begin
		win_nx = window_q;
		thr_nx = thresh_q;
		rec_nx = recov_q;
		rp_nx  = rpoint_q;
		if (cmd.commit_div) begin
			win_nx = tnwc_pkg::sat_add(window_q, ca_inc);
		end else begin
			case (cmd_q)
				tnwc_pkg::CMD_INIT: begin
					win_nx = init_win;
					thr_nx = tnwc_pkg::THRESH_RESET;
					rec_nx = 1'b0;
				end
				tnwc_pkg::CMD_ACK: begin
					if (recov_q) begin
						if (seq_ge_q) begin
							win_nx = thresh_q;
							rec_nx = 1'b0;
						end else begin
							win_nx = tnwc_pkg::sat_add(window_q, W'(mss));
						end
					end else begin
						win_nx = tnwc_pkg::sat_add(window_q, W'(cap_q));
					end
				end
				tnwc_pkg::CMD_DUP_ACK: begin
					if (dup_ok_q && !recov_q) begin
						rp_nx  = sent_q;
						rec_nx = 1'b1;
						thr_nx = thr_new;
						win_nx = tnwc_pkg::sat_add(thr_new, W'(prod_q));
					end
				end
				tnwc_pkg::CMD_TIMEOUT: begin
					rec_nx = 1'b0;
					rp_nx  = sent_q;
					thr_nx = thr_new;
					win_nx = init_win;
				end
				tnwc_pkg::CMD_RESTART: begin
					win_nx = init_win;
					rec_nx = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= tnwc_pkg::IW_RESET;
			thresh_q <= tnwc_pkg::THRESH_RESET;
			recov_q  <= 1'b0;
			rpoint_q <= '0;
		end else if (cmd.commit_exec || cmd.commit_div) begin
			window_q <= win_nx;
			thresh_q <= thr_nx;
			recov_q  <= rec_nx;
			rpoint_q <= rp_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit_exec || cmd.commit_div) begin
			congestion_window    <= win_nx;
			slow_start_threshold <= thr_nx;
			in_recovery          <= rec_nx;
		end
	end

endmodule

`default_nettype wire

FILE: design/tnwc_ctrl.sv
// Sequencing state machine and result valid flag.
// Depends on tnwc_pkg for the state, command and status types.
`default_nettype none

module tnwc_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	input  wire tnwc_pkg::ctrl_status_t status,
	output tnwc_pkg::ctrl_cmd_t         cmd
);

	tnwc_pkg::state_t state_q;
	tnwc_pkg::state_t state_nx;
	logic             mvalid_q;
	logic             out_free;
	logic             commit;

	assign out_free = !mvalid_q || m_tready;
	assign m_tvalid = mvalid_q;
	assign commit   = cmd.commit_exec || cmd.commit_div;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			tnwc_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_nx = tnwc_pkg::ST_EXEC;
				end
			end
			tnwc_pkg::ST_EXEC: begin
				if (status.needs_div) begin
					state_nx = tnwc_pkg::ST_DIVIDE;
				end else if (out_free) begin
					state_nx = tnwc_pkg::ST_IDLE;
				end
			end
			tnwc_pkg::ST_DIVIDE: begin
				if (status.div_done) begin
					state_nx = tnwc_pkg::ST_FINISH;
				end
			end
			tnwc_pkg::ST_FINISH: begin
				if (out_free) begin
					state_nx = tnwc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = tnwc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready         = 1'b0;
		cmd.load         = 1'b0;
		cmd.commit_exec  = 1'b0;
		cmd.div_start    = 1'b0;
		cmd.commit_div   = 1'b0;
		case (state_q)
			tnwc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			tnwc_pkg::ST_EXEC: begin
				cmd.div_start   = status.needs_div;
				cmd.commit_exec = !status.needs_div && out_free;
			end
			tnwc_pkg::ST_FINISH: begin
				cmd.commit_div = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tnwc_pkg::ST_IDLE;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (commit) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
